// ===== hdl/sjet_pkg.sv =====
// ----------------------------------------------------------------------------
// sjet_pkg
// Shared types, constants and code tables for the SJIS / EUC-JP
// transcoder.
// ----------------------------------------------------------------------------
package sjet_pkg;

    localparam int QueueDepthDefault = 4;

    localparam logic [7:0] KanaPrefix = 8'h8E;

    // One converted source byte: up to three output bytes in order.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      count;
        logic            last_text;
    } entry_t;

    // Half-width kana 0xA0..0xDF to full-width JIS.
    function automatic logic [15:0] kana_full(input logic [5:0] idx);
        logic [15:0] r;
        case (idx)
            6'd0:  r = 16'h2121;  6'd1:  r = 16'h2123;  6'd2:  r = 16'h2156;
            6'd3:  r = 16'h2157;  6'd4:  r = 16'h2122;  6'd5:  r = 16'h2126;
            6'd6:  r = 16'h2572;  6'd7:  r = 16'h2521;  6'd8:  r = 16'h2523;
            6'd9:  r = 16'h2525;  6'd10: r = 16'h2527;  6'd11: r = 16'h2529;
            6'd12: r = 16'h2563;  6'd13: r = 16'h2565;  6'd14: r = 16'h2567;
            6'd15: r = 16'h2543;  6'd16: r = 16'h213c;  6'd17: r = 16'h2522;
            6'd18: r = 16'h2524;  6'd19: r = 16'h2526;  6'd20: r = 16'h2528;
            6'd21: r = 16'h252a;  6'd22: r = 16'h252b;  6'd23: r = 16'h252d;
            6'd24: r = 16'h252f;  6'd25: r = 16'h2531;  6'd26: r = 16'h2533;
            6'd27: r = 16'h2535;  6'd28: r = 16'h2537;  6'd29: r = 16'h2539;
            6'd30: r = 16'h253b;  6'd31: r = 16'h253d;  6'd32: r = 16'h253f;
            6'd33: r = 16'h2541;  6'd34: r = 16'h2544;  6'd35: r = 16'h2546;
            6'd36: r = 16'h2548;  6'd37: r = 16'h254a;  6'd38: r = 16'h254b;
            6'd39: r = 16'h254c;  6'd40: r = 16'h254d;  6'd41: r = 16'h254e;
            6'd42: r = 16'h254f;  6'd43: r = 16'h2552;  6'd44: r = 16'h2555;
            6'd45: r = 16'h2558;  6'd46: r = 16'h255b;  6'd47: r = 16'h255e;
            6'd48: r = 16'h255f;  6'd49: r = 16'h2560;  6'd50: r = 16'h2561;
            6'd51: r = 16'h2562;  6'd52: r = 16'h2564;  6'd53: r = 16'h2566;
            6'd54: r = 16'h2568;  6'd55: r = 16'h2569;  6'd56: r = 16'h256a;
            6'd57: r = 16'h256b;  6'd58: r = 16'h256c;  6'd59: r = 16'h256d;
            6'd60: r = 16'h256f;  6'd61: r = 16'h2573;  6'd62: r = 16'h212b;
            6'd63: r = 16'h212c;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // Printable ASCII 0x20..0x7E to full-width JIS.
    function automatic logic [15:0] ascii_full(input logic [6:0] idx);
        logic [15:0] r;
        case (idx)
            7'd0:  r = 16'h2121;  7'd1:  r = 16'h212a;  7'd2:  r = 16'h2149;
            7'd3:  r = 16'h2174;  7'd4:  r = 16'h2170;  7'd5:  r = 16'h2173;
            7'd6:  r = 16'h2175;  7'd7:  r = 16'h2147;  7'd8:  r = 16'h214A;
            7'd9:  r = 16'h214B;  7'd10: r = 16'h2176;  7'd11: r = 16'h215C;
            7'd12: r = 16'h2124;  7'd13: r = 16'h215d;  7'd14: r = 16'h2125;
            7'd15: r = 16'h213F;  7'd16: r = 16'h2330;  7'd17: r = 16'h2331;
            7'd18: r = 16'h2332;  7'd19: r = 16'h2333;  7'd20: r = 16'h2334;
            7'd21: r = 16'h2335;  7'd22: r = 16'h2336;  7'd23: r = 16'h2337;
            7'd24: r = 16'h2338;  7'd25: r = 16'h2339;  7'd26: r = 16'h2127;
            7'd27: r = 16'h2128;  7'd28: r = 16'h2163;  7'd29: r = 16'h2161;
            7'd30: r = 16'h2164;  7'd31: r = 16'h2129;  7'd32: r = 16'h2177;
            7'd33: r = 16'h2341;  7'd34: r = 16'h2342;  7'd35: r = 16'h2343;
            7'd36: r = 16'h2344;  7'd37: r = 16'h2345;  7'd38: r = 16'h2346;
            7'd39: r = 16'h2347;  7'd40: r = 16'h2348;  7'd41: r = 16'h2349;
            7'd42: r = 16'h234a;  7'd43: r = 16'h234b;  7'd44: r = 16'h234c;
            7'd45: r = 16'h234d;  7'd46: r = 16'h234e;  7'd47: r = 16'h234f;
            7'd48: r = 16'h2350;  7'd49: r = 16'h2351;  7'd50: r = 16'h2352;
            7'd51: r = 16'h2353;  7'd52: r = 16'h2354;  7'd53: r = 16'h2355;
            7'd54: r = 16'h2356;  7'd55: r = 16'h2357;  7'd56: r = 16'h2358;
            7'd57: r = 16'h2359;  7'd58: r = 16'h235a;  7'd59: r = 16'h214E;
            7'd60: r = 16'h2140;  7'd61: r = 16'h214f;  7'd62: r = 16'h224A;
            7'd63: r = 16'h2132;  7'd64: r = 16'h2146;  7'd65: r = 16'h2361;
            7'd66: r = 16'h2362;  7'd67: r = 16'h2363;  7'd68: r = 16'h2364;
            7'd69: r = 16'h2365;  7'd70: r = 16'h2366;  7'd71: r = 16'h2367;
            7'd72: r = 16'h2368;  7'd73: r = 16'h2369;  7'd74: r = 16'h236a;
            7'd75: r = 16'h236b;  7'd76: r = 16'h236c;  7'd77: r = 16'h236d;
            7'd78: r = 16'h236e;  7'd79: r = 16'h236f;  7'd80: r = 16'h2370;
            7'd81: r = 16'h2371;  7'd82: r = 16'h2372;  7'd83: r = 16'h2373;
            7'd84: r = 16'h2374;  7'd85: r = 16'h2375;  7'd86: r = 16'h2376;
            7'd87: r = 16'h2377;  7'd88: r = 16'h2378;  7'd89: r = 16'h2379;
            7'd90: r = 16'h237a;  7'd91: r = 16'h2150;  7'd92: r = 16'h2143;
            7'd93: r = 16'h2151;  7'd94: r = 16'h2141;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

    // Second byte of an 0x8E pair to JIS; codes outside the tables give 0.
    function automatic logic [15:0] half_to_full(input logic [7:0] c);
        logic [15:0] r;
        if (c >= 8'hA0 && c <= 8'hDF)
            r = kana_full(6'(c - 8'hA0));
        else if (c < 8'h20 || c >= 8'h7F)
            r = 16'h0000;
        else
            r = ascii_full(7'(c - 8'h20));
        return r;
    endfunction

endpackage

// ===== hdl/sjet_front.sv =====
// ----------------------------------------------------------------------------
// sjet_front
// Accepts source bytes, tracks the held lead byte and the direction
// register, and turns each byte into a queue entry of zero to three bytes.
// ----------------------------------------------------------------------------
module sjet_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_data,
    input  logic                 accept,
    input  logic [7:0]           code_byte,
    input  logic                 end_of_text,
    output logic                 push,
    output sjet_pkg::entry_t     push_entry
);

    logic       direction_reg;
    logic       lead_pending_reg;
    logic       lead_pending_next;
    logic [7:0] lead_byte_reg;
    logic [7:0] lead_byte_next;

    // SJIS pair
    logic       trail_ok;
    logic       is_lead;
    logic       is_kana;
    logic [7:0] lead_x2;
    logic [7:0] sj_hi;
    logic [7:0] sj_lo;

    // EUC-JP pairs
    logic [15:0] jis;
    logic [7:0]  jh;
    logic [7:0]  jl;
    logic [7:0]  jis_hi;
    logic [7:0]  jis_lo;
    logic [7:0]  eh;
    logic [7:0]  euc_hi;
    logic [7:0]  euc_lo;

    sjet_pkg::entry_t ent;
    logic [1:0]       n;

    assign trail_ok = (code_byte >= 8'h40) && (code_byte <= 8'hFC) && (code_byte != 8'h7F);
    assign is_lead  = ((code_byte >= 8'h81) && (code_byte <= 8'h9F))
                   || ((code_byte >= 8'hE0) && (code_byte <= 8'hFC));
    assign is_kana  = (code_byte >= 8'hA1) && (code_byte <= 8'hDF);

    assign lead_x2 = {lead_byte_reg[6:0], 1'b0};

    always_comb
    begin
        if (lead_byte_reg <= 8'h9F)
            sj_hi = (code_byte < 8'h9F) ? lead_x2 - 8'hE1 : lead_x2 - 8'hE0;
        else
            sj_hi = (code_byte < 8'h9F) ? lead_x2 - 8'h61 : lead_x2 - 8'h60;
        if (code_byte < 8'h7F)
            sj_lo = code_byte - 8'h1F;
        else if (code_byte < 8'h9F)
            sj_lo = code_byte - 8'h20;
        else
            sj_lo = code_byte - 8'h7E;
    end

    assign jis = sjet_pkg::half_to_full(code_byte);
    assign jh  = jis[15:8];
    assign jl  = jis[7:0];

    always_comb
    begin
        if (jh[0])
            jis_lo = (jl < 8'h60) ? jl + 8'h1F : jl + 8'h20;
        else
            jis_lo = jl + 8'h7E;
        if (jh < 8'h5F)
            jis_hi = 8'((10'(jh) + 10'h0E1) >> 1);
        else
            jis_hi = 8'((10'(jh) + 10'h161) >> 1);
    end

    assign eh = {1'b0, lead_byte_reg[7:1]};

    always_comb
    begin
        if (lead_byte_reg[0])
        begin
            euc_hi = (eh < 8'h6F) ? eh + 8'h31 : eh + 8'h71;
            euc_lo = (code_byte > 8'hDF) ? code_byte - 8'h60 : code_byte - 8'h61;
        end
        else
        begin
            euc_hi = (eh < 8'h6F) ? eh + 8'h30 : eh + 8'h70;
            euc_lo = code_byte - 8'h02;
        end
    end

    // Assemble the output bytes in order; n counts them.
    always_comb
    begin
        ent.bytes         = '0;
        n                 = 2'd0;
        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        if (!direction_reg)
        begin
            if (lead_pending_reg && trail_ok)
            begin
                ent.bytes[0]      = sj_hi | 8'h80;
                ent.bytes[1]      = sj_lo | 8'h80;
                n                 = 2'd2;
                lead_pending_next = 1'b0;
            end
            else
            begin
                if (lead_pending_reg)
                begin
                    // invalid trail: lead goes out as is, trail handled afresh
                    ent.bytes[0]      = lead_byte_reg;
                    n                 = 2'd1;
                    lead_pending_next = 1'b0;
                end
                if (is_lead)
                begin
                    lead_pending_next = 1'b1;
                    lead_byte_next    = code_byte;
                end
                else if (is_kana)
                begin
                    ent.bytes[n]            = sjet_pkg::KanaPrefix;
                    ent.bytes[2'(n + 2'd1)] = code_byte;
                    n                       = 2'(n + 2'd2);
                end
                else
                begin
                    ent.bytes[n] = code_byte;
                    n            = 2'(n + 2'd1);
                end
            end
        end
        else
        begin
            if (lead_pending_reg)
            begin
                lead_pending_next = 1'b0;
                n                 = 2'd2;
                if (lead_byte_reg == sjet_pkg::KanaPrefix)
                begin
                    ent.bytes[0] = jis_hi;
                    ent.bytes[1] = jis_lo;
                end
                else
                begin
                    ent.bytes[0] = euc_hi;
                    ent.bytes[1] = euc_lo;
                end
            end
            else if (code_byte[7])
            begin
                lead_pending_next = 1'b1;
                lead_byte_next    = code_byte;
            end
            else
            begin
                ent.bytes[0] = code_byte;
                n            = 2'd1;
            end
        end
        if (end_of_text && lead_pending_next)
        begin
            ent.bytes[n]      = lead_byte_next;
            n                 = 2'(n + 2'd1);
            lead_pending_next = 1'b0;
        end
        ent.count     = n;
        ent.last_text = end_of_text;
    end

    assign push       = accept && (n != 2'd0);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg    <= 1'b0;
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= 8'h00;
        end
        else
        begin
            if (cfg_valid)
                direction_reg <= cfg_data;
            if (accept)
            begin
                lead_pending_reg <= lead_pending_next;
                lead_byte_reg    <= lead_byte_next;
            end
        end
    end

endmodule

// ===== hdl/sjet_queue.sv =====
// ----------------------------------------------------------------------------
// sjet_queue
// Short FIFO of converted entries between the front and back parts.
// ----------------------------------------------------------------------------
module sjet_queue
#(
    parameter int QueueDepth = sjet_pkg::QueueDepthDefault
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sjet_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output sjet_pkg::entry_t head
);

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    sjet_pkg::entry_t entry_reg [QueueDepth];

    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] fill_reg;

    assign full  = (fill_reg == CntW'(QueueDepth));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                  : wr_ptr_reg + PtrW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                  : rd_ptr_reg + PtrW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + CntW'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - CntW'(1);
        end
    end

endmodule

// ===== hdl/sjet_back.sv =====
// ----------------------------------------------------------------------------
// sjet_back
// Serializes queue entries into one output byte per transaction, with the
// per-byte and end-of-text flags, through an output register.
// ----------------------------------------------------------------------------
module sjet_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  sjet_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output logic             run_last,
    output logic             text_end
);

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       run_last_reg;
    logic       text_end_reg;
    logic [1:0] idx_reg;
    logic       load;
    logic       last;

    assign load = !empty && (!out_valid_reg || !out_stall);
    assign last = (idx_reg == 2'(head.count - 2'd1));
    assign pop  = load && last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                idx_reg       <= last ? 2'd0 : 2'(idx_reg + 2'd1);
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg <= head.bytes[idx_reg];
            run_last_reg <= last;
            text_end_reg <= last && head.last_text;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign run_last  = run_last_reg;
    assign text_end  = text_end_reg;

endmodule

// ===== hdl/sjis_eucjp_transcoder.sv =====
// ----------------------------------------------------------------------------
// sjis_eucjp_transcoder
// SJIS <-> EUC-JP byte-stream converter, direction set by register.
// ----------------------------------------------------------------------------
// Path: an accepted byte's entry is written into the queue, then loaded into the output register.
// Throughput: one input byte per cycle while the queue is not full (in_stall);
//   output one byte per cycle while out_stall is low, so a source byte yielding
//   2 or 3 bytes sends them in turn, with QueueDepth entries of buffering between front and back.
// Reset: asynchronous active-low; clears direction, held lead, queue, output valid.
module sjis_eucjp_transcoder
#(
    parameter int QueueDepth = sjet_pkg::QueueDepthDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] code_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;
    sjet_pkg::entry_t push_entry;
    sjet_pkg::entry_t head;

    assign cfg_ready = 1'b1;
    assign in_stall  = full;
    assign accept    = in_valid && !full;

    sjet_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .code_byte   (code_byte),
        .end_of_text (end_of_text),
        .push        (push),
        .push_entry  (push_entry)
    );

    sjet_queue #(.QueueDepth(QueueDepth)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .empty      (empty),
        .head       (head)
    );

    sjet_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

endmodule

// ===== hdl/sjet_checker.sv =====
// ----------------------------------------------------------------------------
// sjet_checker
// Port-level checks on the transcoder, bound to the top level.
// ----------------------------------------------------------------------------
module sjet_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_valid,
    input logic       cfg_ready,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_end
);

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
                                   && $stable(run_last) && $stable(text_end))
        else $error("output changed while stalled");

    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> !$past(out_stall))
        else $error("output valid dropped without transaction");

    // end of text is always the last byte of its source byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_last)
        else $error("text_end without run_last");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write not taken");

endmodule

bind sjis_eucjp_transcoder sjet_checker u_sjet_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
);
